### src/middle_ear_biquad_cascade_defines.svh
`ifndef MIDDLE_EAR_BIQUAD_CASCADE_DEFINES_SVH
`define MIDDLE_EAR_BIQUAD_CASCADE_DEFINES_SVH

// Same-cycle check, sampled on clk_i, off while rst_ni is low
`define MEBC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Next-cycle check: cons must hold in the cycle after ante
`define MEBC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/mebc_pkg.sv
`timescale 1ns / 1ps

package mebc_pkg;

  // Fixed field and datapath widths
  localparam int unsigned STATE_BITS = 48;
  localparam int unsigned COEF_BITS  = 32;
  localparam int unsigned COEF_FRAC  = 30;
  localparam int unsigned OUT_BITS   = 32;
  localparam int unsigned SHIFT_BITS = 6;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // Digit-serial multiplier: byte digits over a 40-bit sign-extended multiplier
  localparam int unsigned DIGIT_BITS = 8;
  localparam int unsigned MUL_B_W    = 40;
  localparam int unsigned NUM_DIGITS = MUL_B_W / DIGIT_BITS;
  localparam int unsigned DIG_CNT_W  = $clog2(NUM_DIGITS + 1);
  localparam int unsigned MUL_HI_W   = STATE_BITS + DIGIT_BITS + 1;
  localparam int unsigned PROD_W     = STATE_BITS + MUL_B_W;

  // Section accumulator: x0 plus four floored terms of at most 49 bits each
  localparam int unsigned ACC_W = STATE_BITS + 4;

  localparam logic signed [STATE_BITS-1:0] STATE_MAX = {1'b0, {(STATE_BITS-1){1'b1}}};
  localparam logic signed [STATE_BITS-1:0] STATE_MIN = {1'b1, {(STATE_BITS-1){1'b0}}};
  localparam logic signed [OUT_BITS-1:0]   OUT_MAX   = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam logic signed [OUT_BITS-1:0]   OUT_MIN   = {1'b1, {(OUT_BITS-1){1'b0}}};

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_ONE  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_TWO  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_S1_FB_ONE = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_S1_FB_TWO = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_S2_FB_ONE = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_S2_FB_TWO = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_MANT = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_SHFT = 4'd7;

  // Coefficient set seen by the core
  typedef struct packed {
    logic signed [COEF_BITS-1:0] a1;
    logic signed [COEF_BITS-1:0] a2;
    logic signed [COEF_BITS-1:0] fb1_first;
    logic signed [COEF_BITS-1:0] fb2_first;
    logic signed [COEF_BITS-1:0] fb1_rest;
    logic signed [COEF_BITS-1:0] fb2_rest;
    logic        [COEF_BITS-1:0] gain;
    logic        [SHIFT_BITS-1:0] shift;
  } mebc_coef_t;

  localparam mebc_coef_t COEF_RESET = '{
    a1: '0, a2: '0, fb1_first: '0, fb2_first: '0,
    fb1_rest: '0, fb2_rest: '0, gain: 32'd1, shift: '0
  };

  // Result item from the core
  typedef struct packed {
    logic signed [OUT_BITS-1:0] sample;
    logic                       last;
  } mebc_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_MUL,
    ST_SECT,
    ST_RESULT
  } mebc_state_e;

endpackage

### src/mebc_digit_mul.sv
`timescale 1ns / 1ps

// Signed digit-serial multiplier, one byte of the multiplier per cycle.
// Low digits are unsigned, the top digit carries the sign.
module mebc_digit_mul import mebc_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [STATE_BITS-1:0] mcand_i,
  input  logic signed [MUL_B_W-1:0]    mplier_i,
  output logic                         busy_o,
  output logic signed [PROD_W-1:0]     prod_o
);

  logic                         busy_q;
  logic [DIG_CNT_W-1:0]         cnt_q;
  logic signed [STATE_BITS-1:0] mcand_q;
  logic [MUL_B_W-1:0]           mplier_q;
  logic signed [MUL_HI_W-1:0]   hi_q;
  logic [MUL_B_W-1:0]           lo_q;

  logic                         last_dig;
  logic signed [DIGIT_BITS:0]   digit;
  logic signed [MUL_HI_W-1:0]   mcand_x;
  logic signed [MUL_HI_W-1:0]   digit_x;
  logic signed [MUL_HI_W-1:0]   pp;
  logic signed [MUL_HI_W-1:0]   sum;

  // Partial product of the current digit plus running high part
  always_comb begin
    last_dig = (cnt_q == DIG_CNT_W'(1));
    digit    = last_dig ? $signed({mplier_q[DIGIT_BITS-1], mplier_q[DIGIT_BITS-1:0]})
                        : $signed({1'b0, mplier_q[DIGIT_BITS-1:0]});
    mcand_x  = MUL_HI_W'(mcand_q);
    digit_x  = MUL_HI_W'(digit);
    pp       = mcand_x * digit_x;
    sum      = hi_q + pp;
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= DIG_CNT_W'(NUM_DIGITS);
    end else if (busy_q) begin
      cnt_q <= cnt_q - DIG_CNT_W'(1);
      if (last_dig) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Shift registers: multiplier digits out, product bits in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q  <= mcand_i;
      mplier_q <= mplier_i;
      hi_q     <= '0;
    end else if (busy_q) begin
      mplier_q <= mplier_q >> DIGIT_BITS;
      hi_q     <= sum >>> DIGIT_BITS;
      lo_q     <= {sum[DIGIT_BITS-1:0], lo_q[MUL_B_W-1:DIGIT_BITS]};
    end
  end

  assign busy_o = busy_q;
  assign prod_o = $signed({hi_q[STATE_BITS-1:0], lo_q});

endmodule

### src/mebc_cfg.sv
`timescale 1ns / 1ps

// Coefficient and gain registers
module mebc_cfg import mebc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output mebc_coef_t            coef_o
);

  mebc_coef_t coef_q;

  // Unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= COEF_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ZERO_ONE:  coef_q.a1        <= $signed(cfg_data_i[COEF_BITS-1:0]);
        REG_ZERO_TWO:  coef_q.a2        <= $signed(cfg_data_i[COEF_BITS-1:0]);
        REG_S1_FB_ONE: coef_q.fb1_first <= $signed(cfg_data_i[COEF_BITS-1:0]);
        REG_S1_FB_TWO: coef_q.fb2_first <= $signed(cfg_data_i[COEF_BITS-1:0]);
        REG_S2_FB_ONE: coef_q.fb1_rest  <= $signed(cfg_data_i[COEF_BITS-1:0]);
        REG_S2_FB_TWO: coef_q.fb2_rest  <= $signed(cfg_data_i[COEF_BITS-1:0]);
        REG_GAIN_MANT: coef_q.gain      <= cfg_data_i[COEF_BITS-1:0];
        REG_GAIN_SHFT: coef_q.shift     <= cfg_data_i[SHIFT_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign coef_o      = coef_q;

endmodule

### src/mebc_core.sv
`timescale 1ns / 1ps

// Sequencer and history for the biquad cascade. One shared digit-serial
// multiplier computes the four terms of each section, then the gain.
module mebc_core import mebc_pkg::*; #(
  parameter int unsigned SECTIONS = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [STATE_BITS-1:0] in_sample_i,
  input  logic                         in_last_i,
  input  mebc_coef_t                   coef_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output mebc_res_t                    res_o
);

  localparam int unsigned SEC_CNT_W = $clog2(SECTIONS + 1);

  // Term order within a section
  localparam logic [1:0] TERM_X1 = 2'd0;
  localparam logic [1:0] TERM_X2 = 2'd1;
  localparam logic [1:0] TERM_Y1 = 2'd2;
  localparam logic [1:0] TERM_Y2 = 2'd3;

  mebc_state_e          state_q, state_d;
  logic [1:0]           term_q, term_d;
  logic [SEC_CNT_W-1:0] sec_q, sec_d;
  logic                 last_q;

  logic signed [STATE_BITS-1:0] x0w_q, x1w_q, x2w_q;
  logic signed [ACC_W-1:0]      acc_q;
  logic signed [STATE_BITS-1:0] inh_q  [2];
  logic signed [STATE_BITS-1:0] hist_q [SECTIONS][2];

  logic                         mul_start, mul_busy;
  logic signed [STATE_BITS-1:0] mul_a;
  logic signed [MUL_B_W-1:0]    mul_b;
  logic signed [PROD_W-1:0]     mul_prod;

  logic                         gain_phase, first_sec;
  logic signed [COEF_BITS-1:0]  fb1, fb2;
  logic signed [ACC_W-1:0]      term_val;
  logic                         y_ovf;
  logic signed [STATE_BITS-1:0] y_sat;
  logic signed [PROD_W-1:0]     gain_sh;
  logic                         out_ovf;
  logic signed [OUT_BITS-1:0]   out_sat;
  logic                         take_in, term_done, res_fire;

  assign gain_phase = (sec_q == SEC_CNT_W'(SECTIONS));
  assign first_sec  = (sec_q == '0);
  assign fb1        = first_sec ? coef_i.fb1_first : coef_i.fb1_rest;
  assign fb2        = first_sec ? coef_i.fb2_first : coef_i.fb2_rest;

  // Operand select for the term being started
  always_comb begin
    if (gain_phase) begin
      mul_a = x0w_q;
      mul_b = $signed({{(MUL_B_W-COEF_BITS){1'b0}}, coef_i.gain});
    end else begin
      unique case (term_d)
        TERM_X1: begin
          mul_a = x1w_q;
          mul_b = MUL_B_W'(coef_i.a1);
        end
        TERM_X2: begin
          mul_a = x2w_q;
          mul_b = MUL_B_W'(coef_i.a2);
        end
        TERM_Y1: begin
          mul_a = hist_q[0][0];
          mul_b = MUL_B_W'(fb1);
        end
        TERM_Y2: begin
          mul_a = hist_q[0][1];
          mul_b = MUL_B_W'(fb2);
        end
      endcase
    end
  end

  mebc_digit_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (mul_a),
    .mplier_i (mul_b),
    .busy_o   (mul_busy),
    .prod_o   (mul_prod)
  );

  // Floored Q2.30 term, section clamp, output gain shift and clamp
  always_comb begin
    term_val = $signed(mul_prod[COEF_FRAC +: ACC_W]);
    y_ovf    = !((&acc_q[ACC_W-1:STATE_BITS-1]) || (~|acc_q[ACC_W-1:STATE_BITS-1]));
    y_sat    = y_ovf ? (acc_q[ACC_W-1] ? STATE_MIN : STATE_MAX) : acc_q[STATE_BITS-1:0];
    gain_sh  = mul_prod >>> coef_i.shift;
    out_ovf  = !((&gain_sh[PROD_W-1:OUT_BITS-1]) || (~|gain_sh[PROD_W-1:OUT_BITS-1]));
    out_sat  = out_ovf ? (gain_sh[PROD_W-1] ? OUT_MIN : OUT_MAX) : gain_sh[OUT_BITS-1:0];
  end

  // Next state and handshake outputs
  always_comb begin
    state_d     = state_q;
    term_d      = term_q;
    sec_d       = sec_q;
    mul_start   = 1'b0;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_START;
          term_d  = TERM_X1;
          sec_d   = '0;
        end
      end
      ST_START: begin
        mul_start = 1'b1;
        state_d   = ST_MUL;
      end
      ST_MUL: begin
        if (!mul_busy) begin
          if (gain_phase) begin
            state_d = ST_RESULT;
          end else if (term_q == TERM_Y2) begin
            state_d = ST_SECT;
          end else begin
            // accumulate this term and start the next in the same cycle
            mul_start = 1'b1;
            term_d    = term_q + 2'd1;
          end
        end
      end
      ST_SECT: begin
        sec_d   = sec_q + SEC_CNT_W'(1);
        term_d  = TERM_X1;
        state_d = ST_START;
      end
      ST_RESULT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign take_in   = (state_q == ST_IDLE) && in_valid_i;
  assign term_done = (state_q == ST_MUL) && !mul_busy && !gain_phase;
  assign res_fire  = (state_q == ST_RESULT) && res_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      term_q  <= TERM_X1;
      sec_q   <= '0;
    end else begin
      state_q <= state_d;
      term_q  <= term_d;
      sec_q   <= sec_d;
    end
  end

  // Filter history: input pair plus a ring of section pairs, head is the
  // section being worked on; a full item rotates the ring back in place.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inh_q[0] <= '0;
      inh_q[1] <= '0;
      for (int i = 0; i < SECTIONS; i++) begin
        hist_q[i][0] <= '0;
        hist_q[i][1] <= '0;
      end
    end else if (take_in) begin
      inh_q[1] <= inh_q[0];
      inh_q[0] <= in_sample_i;
    end else if (state_q == ST_SECT) begin
      for (int i = 0; i < SECTIONS - 1; i++) begin
        hist_q[i][0] <= hist_q[i+1][0];
        hist_q[i][1] <= hist_q[i+1][1];
      end
      hist_q[SECTIONS-1][0] <= y_sat;
      hist_q[SECTIONS-1][1] <= hist_q[0][0];
    end else if (res_fire && last_q) begin
      inh_q[0] <= '0;
      inh_q[1] <= '0;
      for (int i = 0; i < SECTIONS; i++) begin
        hist_q[i][0] <= '0;
        hist_q[i][1] <= '0;
      end
    end
  end

  // Working operands and section accumulator
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      x0w_q  <= in_sample_i;
      x1w_q  <= inh_q[0];
      x2w_q  <= inh_q[1];
      acc_q  <= ACC_W'(in_sample_i);
      last_q <= in_last_i;
    end else if (term_done) begin
      acc_q <= acc_q + term_val;
    end else if (state_q == ST_SECT) begin
      // next section's input history is this section's output history
      x0w_q <= y_sat;
      x1w_q <= hist_q[0][0];
      x2w_q <= hist_q[0][1];
      acc_q <= ACC_W'(y_sat);
    end
  end

  assign res_o.sample = out_sat;
  assign res_o.last   = last_q;

endmodule

### src/middle_ear_biquad_cascade.sv
`timescale 1ns / 1ps
//  channel  | dir | handshake                    | payload
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata: sample_in, tlast: last_in
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata: sample_out, tlast: last_out
//  cfg      | in  | cfg_valid_i/cfg_ready_o      | cfg_index_i, cfg_data_i
//
// An item runs through the shared multiplier as 4*SECTIONS + 1 products at five
// byte digits each before its result reaches the output register; the core
// accepts the next item only after that result has moved into the register.
// cfg_ready_o is always high. Reset clears history, loads coefficient defaults
// and empties the output; a full output register holds the core with its
// result, and inputs then wait.
`include "middle_ear_biquad_cascade_defines.svh"

module middle_ear_biquad_cascade import mebc_pkg::*; #(
  parameter int unsigned SECTIONS    = 2,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,  // sample_in
  input  logic                                 s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [OUT_BITS-1:0]                  m_axis_tdata,  // sample_out
  output logic                                 m_axis_tlast,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]                 cfg_index_i,
  input  logic [CFG_DATA_W-1:0]                cfg_data_i
);

  mebc_coef_t                   coef;
  logic signed [STATE_BITS-1:0] sample_ext;
  logic                         res_valid, res_ready;
  mebc_res_t                    res;

  logic                         out_valid_q;
  logic [OUT_BITS-1:0]          out_data_q;
  logic                         out_last_q;

  assign sample_ext = STATE_BITS'($signed(s_axis_tdata[SAMPLE_BITS-1:0]));

  mebc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .coef_o      (coef)
  );

  mebc_core #(
    .SECTIONS (SECTIONS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_sample_i (sample_ext),
    .in_last_i   (s_axis_tlast),
    .coef_i      (coef),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: free when empty or drained this cycle
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res.sample;
      out_last_q <= res.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // Checks
  `MEBC_ASSERT(a_ready_not_holding, s_axis_tready |-> !res_valid, "input ready while result held")
  `MEBC_ASSERT_NEXT(a_no_instant_result, s_axis_tvalid && s_axis_tready, !res_valid, "result right after accept")
  `MEBC_ASSERT_NEXT(a_idle_after_result, res_valid && res_ready, s_axis_tready, "core not idle after result")

endmodule

### test/tb_middle_ear_biquad_cascade.sv
`timescale 1ns / 1ps

module tb_middle_ear_biquad_cascade;
  import mebc_pkg::*;

  localparam int unsigned SECTIONS    = 2;
  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned LIMIT       = 1000000;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_ITEMS = 103;
  localparam int unsigned PRESSURE_PH = 4;
  localparam int unsigned HOLD_LEN    = 400;
  localparam int unsigned DRAIN_WAIT  = 80;

  localparam logic [CFG_IDX_W-1:0]   REG_UNMAPPED = 4'd11;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX   = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN   = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [COEF_BITS-1:0]   COEF_TOP     = 32'h7FFF_FFFF;
  localparam logic [COEF_BITS-1:0]   COEF_BOTTOM  = 32'h8000_0000;
  localparam logic [COEF_BITS-1:0]   ALL_ONES     = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last;
  } sample_item_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [TDATA_W-1:0]   s_axis_tdata = '0;
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_BITS-1:0]  m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  middle_ear_biquad_cascade #(
    .SECTIONS   (SECTIONS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // sample_in
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // sample_out
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Clock and run limit
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  int unsigned cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Filter state and coefficient copy
  mebc_coef_t coef = COEF_RESET;
  longint     in_hist [2];
  longint     sect_hist [SECTIONS][2];

  sample_item_t pending_samples [$];
  mebc_res_t    expected_samples [$];
  int unsigned  mismatches = 0;

  bit          gaps_on = 1'b1;
  int unsigned phase_no = 0;
  bit          in_fire = 1'b0;

  initial begin
    in_hist = '{0, 0};
    foreach (sect_hist[s, k]) sect_hist[s][k] = 0;
  end

  function automatic longint clamp_to(longint v, int unsigned bits);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint add_sat(longint a, longint b);
    logic signed [64:0] sum;
    logic signed [64:0] hi;
    logic signed [64:0] lo;
    hi  = 64'sh7FFF_FFFF_FFFF_FFFF;
    lo  = -hi - 1;
    sum = a + b;
    if (sum > hi) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (sum < lo) return 64'sh8000_0000_0000_0000;
    return longint'(sum);
  endfunction

  // floor(h * c / 2^sh), saturated to 64 bits
  function automatic longint scaled_product(longint h, logic signed [32:0] c,
                                            int unsigned sh);
    logic signed [127:0] prod;
    logic signed [127:0] cw;
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi   = 64'sh7FFF_FFFF_FFFF_FFFF;
    lo   = -hi - 1;
    prod = h;
    cw   = c;
    prod = (prod * cw) >>> sh;
    if (prod > hi) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (prod < lo) return 64'sh8000_0000_0000_0000;
    return longint'(prod);
  endfunction

  // One sample through the cascade, then gain, shift and output clamp
  function automatic mebc_res_t filter_sample(logic [SAMPLE_BITS-1:0] raw, logic last);
    logic signed [SAMPLE_BITS-1:0] raw_s;
    longint x0, x1, x2, y1, y2, y, acc;
    logic signed [32:0] fb1, fb2;
    mebc_res_t res;
    raw_s = raw;
    x0 = raw_s;
    x1 = in_hist[0];
    x2 = in_hist[1];
    in_hist[1] = in_hist[0];
    in_hist[0] = x0;
    y = 0;
    for (int s = 0; s < SECTIONS; s++) begin
      fb1 = (s == 0) ? coef.fb1_first : coef.fb1_rest;
      fb2 = (s == 0) ? coef.fb2_first : coef.fb2_rest;
      y1  = sect_hist[s][0];
      y2  = sect_hist[s][1];
      acc = x0;
      acc = add_sat(acc, scaled_product(x1, coef.a1, COEF_FRAC));
      acc = add_sat(acc, scaled_product(x2, coef.a2, COEF_FRAC));
      acc = add_sat(acc, scaled_product(y1, fb1, COEF_FRAC));
      acc = add_sat(acc, scaled_product(y2, fb2, COEF_FRAC));
      y   = clamp_to(acc, STATE_BITS);
      // next section takes this section's history as its input history
      x0 = y;
      x1 = y1;
      x2 = y2;
      sect_hist[s][1] = y1;
      sect_hist[s][0] = y;
    end
    res.sample = OUT_BITS'(clamp_to(scaled_product(y, {1'b0, coef.gain}, coef.shift),
                                    OUT_BITS));
    res.last   = last;
    if (last) begin
      in_hist = '{0, 0};
      foreach (sect_hist[s, k]) sect_hist[s][k] = 0;
    end
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 60);
  endfunction

  // Monitor: config copy, result check, prediction on accepted items
  always @(posedge clk_i) begin
    mebc_res_t got;
    mebc_res_t want;
    in_fire = rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_ZERO_ONE:  coef.a1        = cfg_data_i;
        REG_ZERO_TWO:  coef.a2        = cfg_data_i;
        REG_S1_FB_ONE: coef.fb1_first = cfg_data_i;
        REG_S1_FB_TWO: coef.fb2_first = cfg_data_i;
        REG_S2_FB_ONE: coef.fb1_rest  = cfg_data_i;
        REG_S2_FB_TWO: coef.fb2_rest  = cfg_data_i;
        REG_GAIN_MANT: coef.gain      = cfg_data_i;
        REG_GAIN_SHFT: coef.shift     = cfg_data_i[SHIFT_BITS-1:0];
        default: ;
      endcase
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.sample = m_axis_tdata;
      got.last   = m_axis_tlast;
      if (expected_samples.size() == 0) begin
        $error("unexpected output item: sample_out %0d", $signed(got.sample));
        mismatches++;
      end else begin
        want = expected_samples.pop_front();
        if (got.sample !== want.sample) begin
          $error("sample_out: expected %0d, actual %0d",
                 $signed(want.sample), $signed(got.sample));
          mismatches++;
        end
        if (got.last !== want.last) begin
          $error("last_out: expected %0b, actual %0b", want.last, got.last);
          mismatches++;
        end
      end
    end
    if (in_fire)
      expected_samples.push_back(filter_sample(s_axis_tdata[SAMPLE_BITS-1:0], s_axis_tlast));
  end

  // Driver: offers pending items with random gaps
  int unsigned in_gap = 0;

  always @(negedge clk_i) begin
    sample_item_t nxt;
    if (rst_ni && (!s_axis_tvalid || in_fire)) begin
      if (in_fire) in_gap = gaps_on ? pick_gap() : 0;
      if (in_gap != 0 || pending_samples.size() == 0) begin
        if (in_gap != 0) in_gap--;
        s_axis_tvalid <= 1'b0;
      end else begin
        nxt = pending_samples.pop_front();
        s_axis_tdata  <= TDATA_W'(nxt.sample);
        s_axis_tlast  <= nxt.last;
        s_axis_tvalid <= 1'b1;
      end
    end
  end

  // Receiver: random stalls, one long hold while the sender keeps offering
  int unsigned stall_left = 0;
  int unsigned hold_left  = 0;
  bit          held_once  = 1'b0;

  always @(negedge clk_i) begin
    if (rst_ni && phase_no == PRESSURE_PH && !held_once && s_axis_tvalid) begin
      held_once = 1'b1;
      hold_left = HOLD_LEN;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (gaps_on && $urandom_range(0, 5) == 0) stall_left = pick_gap();
    end
  end

  // Config writes: valid stays high across back-to-back writes
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_config(logic [31:0] a1, logic [31:0] a2, logic [31:0] f1,
                             logic [31:0] f2, logic [31:0] r1, logic [31:0] r2,
                             logic [31:0] gain, logic [31:0] shift_word);
    write_reg(REG_ZERO_ONE, a1);
    write_reg(REG_ZERO_TWO, a2);
    write_reg(REG_S1_FB_ONE, f1);
    write_reg(REG_S1_FB_TWO, f2);
    write_reg(REG_S2_FB_ONE, r1);
    write_reg(REG_S2_FB_TWO, r2);
    write_reg(REG_GAIN_MANT, gain);
    write_reg(REG_GAIN_SHFT, shift_word);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coef(int unsigned span);
    logic [31:0] r;
    r = $urandom_range(0, 2 * span);
    return r - span;
  endfunction

  task automatic load_random_config();
    int unsigned style;
    logic [31:0] gain;
    logic [31:0] shift_word;
    style = $urandom_range(0, 3);
    gain  = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom;
    if (style == 0) begin
      shift_word = $urandom;
      load_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  gain, shift_word);
    end else begin
      // mostly well-behaved sections, coefficients near unity
      shift_word = ($urandom & ~32'h3F) | $urandom_range(28, 44);
      load_config(rand_coef(32'h4000_0000), rand_coef(32'h4000_0000),
                  rand_coef(32'h6000_0000), rand_coef(32'h3C00_0000),
                  rand_coef(32'h6000_0000), rand_coef(32'h3C00_0000),
                  gain, shift_word);
    end
  endtask

  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return SAMPLE_BITS'($urandom);
    if (r < 85) return SAMPLE_BITS'($urandom_range(0, 8191) - 4096);
    if (r < 93) return SAMPLE_MAX;
    return SAMPLE_MIN;
  endfunction

  task automatic queue_sample(logic [SAMPLE_BITS-1:0] smp, logic last);
    sample_item_t it;
    it.sample = smp;
    it.last   = last;
    pending_samples.push_back(it);
  endtask

  task automatic wait_idle();
    while (pending_samples.size() != 0 || s_axis_tvalid || expected_samples.size() != 0)
      @(posedge clk_i);
  endtask

  // Stimulus
  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset coefficients: the cascade passes samples straight through
    queue_sample('0, 1'b0);
    queue_sample(SAMPLE_MAX, 1'b0);
    queue_sample(SAMPLE_MIN, 1'b0);
    queue_sample('1, 1'b0);
    queue_sample(SAMPLE_BITS'(1), 1'b0);
    queue_sample({(SAMPLE_BITS/2){2'b01}}, 1'b0);
    queue_sample({(SAMPLE_BITS/2){2'b10}}, 1'b1);
    wait_idle();

    // largest coefficients and gain: section and output saturation
    load_config(COEF_TOP, COEF_TOP, COEF_TOP, COEF_TOP, COEF_TOP, COEF_TOP,
                ALL_ONES, 32'd0);
    repeat (7) queue_sample(SAMPLE_MAX, 1'b0);
    queue_sample(SAMPLE_MAX, 1'b1);
    wait_idle();

    // most negative coefficients, widest shift, plus an unmapped register
    load_config(COEF_BOTTOM, COEF_BOTTOM, COEF_BOTTOM, COEF_BOTTOM, COEF_BOTTOM,
                COEF_BOTTOM, ALL_ONES, ALL_ONES);
    write_reg(REG_UNMAPPED, ALL_ONES);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    for (int i = 0; i < 7; i++) queue_sample((i % 2) ? SAMPLE_MIN : SAMPLE_MAX, 1'b0);
    queue_sample(SAMPLE_MIN, 1'b1);
    wait_idle();

    // random phases, each with its own coefficient set and random frame lengths
    for (int p = 0; p < PHASES; p++) begin
      load_random_config();
      gaps_on  = !(p == 2 || p == PRESSURE_PH || p == 7);
      @(posedge clk_i);
      phase_no = p;
      for (int i = 0; i < PHASE_ITEMS; i++)
        queue_sample(rand_sample(), $urandom_range(0, 31) == 0);
      wait_idle();
    end

    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
